// ===== sv/query_param_extract_decode_macros.svh =====
`ifndef QUERY_PARAM_EXTRACT_DECODE_MACROS_SVH
`define QUERY_PARAM_EXTRACT_DECODE_MACROS_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define QPX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define QPX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/qpx_pkg.sv =====
`default_nettype none

package qpx_pkg;

  localparam int MAX_KEY_BYTES = 8;

  // results one path word can cause, and depth of the result-group queue
  localparam int QPX_RESULTS = 4;
  localparam int QPX_N_W     = $clog2(QPX_RESULTS + 1);
  localparam int QPX_DEPTH   = 4;
  localparam int QPX_CNT_W   = $clog2(QPX_DEPTH + 1);
  localparam int QPX_PTR_W   = $clog2(QPX_DEPTH);

  // config register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_CHARS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_CAPACITY = 2'd2;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_ABSENT   = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       end_mark;
    status_t    status;
  } result_t;

  // all results of one path word, in order; n of them are live
  typedef struct packed {
    result_t [QPX_RESULTS-1:0] res;
    logic [QPX_N_W-1:0]        n;
  } group_t;

endpackage

`default_nettype wire

// ===== sv/qpx_path_if.sv =====
`default_nettype none

interface qpx_path_if;
  logic       valid;
  logic       ready;
  logic [7:0] path_byte;
  logic       final_byte;

  modport source (output valid, output path_byte, output final_byte, input ready);
  modport sink   (input valid, input path_byte, input final_byte, output ready);
endinterface

`default_nettype wire

// ===== sv/qpx_result_if.sv =====
`default_nettype none

interface qpx_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] value_byte;
  logic       byte_valid;
  logic       end_mark;
  logic [1:0] status;

  modport source (output valid, output value_byte, output byte_valid,
                  output end_mark, output status, input ready);
  modport sink   (input valid, input value_byte, input byte_valid,
                  input end_mark, input status, output ready);
endinterface

`default_nettype wire

// ===== sv/qpx_step.sv =====
`default_nettype none

// Parser state and per-word decode. One word per cycle when item_valid.
module qpx_step (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              item_valid,
  input  wire logic [7:0]        path_byte,
  input  wire logic              final_byte,
  input  wire logic [63:0]       key_chars,
  input  wire logic [3:0]        key_length,
  input  wire logic [15:0]       value_capacity,
  output qpx_pkg::group_t        grp
);
  import qpx_pkg::*;

  typedef enum logic [2:0] {
    PH_SEEK,
    PH_KEY,
    PH_SKIP,
    PH_VALUE,
    PH_DONE
  } phase_t;

  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PCT   = 8'h25;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic [7:0]  fh_r, fh_nxt;
  logic [15:0] wc_r, wc_nxt;
  logic [QPX_RESULTS-1:0] end_marks;

  function automatic logic is_hex(input logic [7:0] ch);
    return (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h61 && ch <= 8'h66) ||
           (ch >= 8'h41 && ch <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] ch);
    logic [7:0] d;
    d = 8'h00;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      d = ch - 8'h30;
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      d = ch - 8'h57;
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      d = ch - 8'h37;
    end
    return d[3:0];
  endfunction

  always_comb begin
    phase_t             ph;
    logic [3:0]         pos;
    logic [1:0]         pend;
    logic [7:0]         fh;
    logic [15:0]        wc;
    logic [2:0][7:0]    em;
    logic [1:0]         n_em;
    logic               do_c;
    logic               fin_found;
    logic               fin_absent;
    logic               closed;
    logic [3:0]         klen;
    logic [7:0]         kb;
    logic [QPX_N_W-1:0] nres;
    result_t [QPX_RESULTS-1:0] res;

    ph         = phase_r;
    pos        = pos_r;
    pend       = pend_r;
    fh         = fh_r;
    wc         = wc_r;
    em         = '0;
    n_em       = '0;
    do_c       = 1'b0;
    fin_found  = 1'b0;
    fin_absent = 1'b0;
    closed     = 1'b0;
    nres       = '0;
    res        = '0;
    klen = (key_length > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES) : key_length;
    kb   = key_chars[{pos[2:0], 3'b000} +: 8];

    unique case (ph)
      PH_SEEK: begin
        if (path_byte == CH_QUEST) begin
          ph  = PH_KEY;
          pos = '0;
        end
      end
      PH_KEY: begin
        if (path_byte == CH_AMP) begin
          pos = '0;
        end else if (pos < klen) begin
          if (path_byte == kb) pos = pos + 4'd1;
          else ph = PH_SKIP;
        end else if (path_byte == CH_EQ) begin
          ph   = PH_VALUE;
          wc   = '0;
          pend = '0;
        end else begin
          ph = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (path_byte == CH_AMP) begin
          ph  = PH_KEY;
          pos = '0;
        end
      end
      PH_VALUE: begin
        do_c = 1'b1;
        if (pend == 2'd1) begin
          if (is_hex(path_byte)) begin
            fh   = path_byte;
            pend = 2'd2;
            do_c = 1'b0;
          end else begin
            pend     = 2'd0;
            em[n_em] = CH_PCT;
            n_em     = n_em + 2'd1;
          end
        end else if (pend == 2'd2) begin
          pend = 2'd0;
          if (is_hex(path_byte)) begin
            em[n_em] = {hex_val(fh), hex_val(path_byte)};
            n_em     = n_em + 2'd1;
            do_c     = 1'b0;
          end else begin
            em[n_em] = CH_PCT;
            n_em     = n_em + 2'd1;
            em[n_em] = fh;
            n_em     = n_em + 2'd1;
          end
        end
        if (do_c) begin
          if (path_byte == CH_AMP) begin
            fin_found = 1'b1;
          end else if (path_byte == CH_PCT) begin
            pend = 2'd1;
          end else begin
            em[n_em] = path_byte;
            n_em     = n_em + 2'd1;
          end
        end
      end
      PH_DONE: ;
      default: ;
    endcase

    // end of path: flush a dangling escape literally, or report no match
    if (final_byte) begin
      if (ph == PH_VALUE && !fin_found) begin
        if (pend != 2'd0) begin
          em[n_em] = CH_PCT;
          n_em     = n_em + 2'd1;
        end
        if (pend == 2'd2) begin
          em[n_em] = fh;
          n_em     = n_em + 2'd1;
        end
        fin_found = 1'b1;
      end else if (ph != PH_VALUE && ph != PH_DONE) begin
        fin_absent = 1'b1;
      end
    end

    // capacity check per emitted byte; too long replaces the byte that missed
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < n_em && !closed) begin
        if ({1'b0, wc} + 17'd1 >= {1'b0, value_capacity}) begin
          res[nres[1:0]] = '{value_byte: 8'h00, byte_valid: 1'b0,
                             end_mark: 1'b1, status: ST_TOO_LONG};
          nres   = nres + QPX_N_W'(1);
          closed = 1'b1;
        end else begin
          res[nres[1:0]] = '{value_byte: em[2'(i)], byte_valid: 1'b1,
                             end_mark: 1'b0, status: ST_FOUND};
          nres = nres + QPX_N_W'(1);
          wc   = wc + 16'd1;
        end
      end
    end
    if (fin_found && !closed) begin
      res[nres[1:0]] = '{value_byte: 8'h00, byte_valid: 1'b0,
                         end_mark: 1'b1, status: ST_FOUND};
      nres   = nres + QPX_N_W'(1);
      closed = 1'b1;
    end
    if (fin_absent) begin
      res[nres[1:0]] = '{value_byte: 8'h00, byte_valid: 1'b0,
                         end_mark: 1'b1, status: ST_ABSENT};
      nres = nres + QPX_N_W'(1);
    end
    if (closed) ph = PH_DONE;

    if (final_byte) begin
      ph   = PH_SEEK;
      pos  = '0;
      pend = '0;
      fh   = '0;
      wc   = '0;
    end

    phase_nxt = ph;
    pos_nxt   = pos;
    pend_nxt  = pend;
    fh_nxt    = fh;
    wc_nxt    = wc;
    grp.res   = res;
    grp.n     = nres;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEEK;
      pos_r   <= '0;
      pend_r  <= '0;
      fh_r    <= '0;
      wc_r    <= '0;
    end else if (item_valid) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      pend_r  <= pend_nxt;
      fh_r    <= fh_nxt;
      wc_r    <= wc_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < QPX_RESULTS; i++) begin
      end_marks[i] = grp.res[i].end_mark;
    end
  end

`include "query_param_extract_decode_macros.svh"

  `QPX_ASSERT_NEXT(a_final_rearms, item_valid && final_byte, phase_r == PH_SEEK, "state not cleared after last word")
  `QPX_ASSERT_NOW(a_one_close, item_valid, $countones(end_marks) <= 1, "more than one closing result in a word")
  `QPX_ASSERT_NOW(a_final_closes, item_valid && final_byte && phase_r != PH_DONE, grp.n != '0, "last word left path unclosed")

endmodule

`default_nettype wire

// ===== sv/query_param_extract_decode.sv =====
`default_nettype none

// Query parameter extractor with percent decoding. Path words (one byte each,
// final_byte on the last) enter at up to one per cycle. A word is latched in
// an input register, decoded in the next cycle against the key held in the
// config registers, and its results (zero to four) go as one group into a
// four-group queue; the result port then presents them one word per cycle
// while out_result.ready is high. in_path stays ready while the queue plus
// the input register hold fewer than four groups, so the input rate is one
// word per cycle as long as results are drained as fast as they are produced;
// words that fan out to several results (malformed escapes, closing) are
// bounded by the one-result-per-cycle output port. Each path ends with
// exactly one end_mark result carrying the status.
// Config (key_chars, key_length, value_capacity) is written through cfg_we /
// cfg_index / cfg_data and must only change while the block is idle.
module query_param_extract_decode (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  qpx_path_if.sink                           in_path,
  qpx_result_if.source                       out_result,
  input  wire logic                          cfg_we,
  input  wire logic [qpx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]                   cfg_data
);
  import qpx_pkg::*;

  // config registers
  logic [63:0] key_chars_r;
  logic [3:0]  key_length_r;
  logic [15:0] value_capacity_r;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_final_r;

  // result-group queue
  group_t                grp;
  group_t                grp_mem [QPX_DEPTH];
  group_t                head;
  logic [QPX_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QPX_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [1:0]            sub_r;
  logic                  in_fire, out_fire, push, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_chars_r      <= '0;
      key_length_r     <= '0;
      value_capacity_r <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_CHARS:      key_chars_r      <= cfg_data;
        CFG_KEY_LENGTH:     key_length_r     <= cfg_data[3:0];
        CFG_VALUE_CAPACITY: value_capacity_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // reserve a queue slot for the word sitting in the input register
  assign in_path.ready = (cnt_r + QPX_CNT_W'(s1_valid_r)) < QPX_CNT_W'(QPX_DEPTH);
  assign in_fire       = in_path.valid && in_path.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r  <= in_path.path_byte;
      s1_final_r <= in_path.final_byte;
    end
  end

  qpx_step u_step (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (s1_valid_r),
    .path_byte      (s1_byte_r),
    .final_byte     (s1_final_r),
    .key_chars      (key_chars_r),
    .key_length     (key_length_r),
    .value_capacity (value_capacity_r),
    .grp            (grp)
  );

  // words that cause no result push nothing
  assign push     = s1_valid_r && (grp.n != '0);
  assign head     = grp_mem[rd_ptr_r];
  assign out_fire = out_result.valid && out_result.ready;
  assign pop      = out_fire && ({1'b0, sub_r} == head.n - QPX_N_W'(1));
  assign cnt_nxt  = cnt_r + QPX_CNT_W'(push) - QPX_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push) grp_mem[wr_ptr_r] <= grp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      sub_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + QPX_PTR_W'(1);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPX_PTR_W'(1);
        sub_r    <= '0;
      end else if (out_fire) begin
        sub_r <= sub_r + 2'd1;
      end
    end
  end

  assign out_result.valid      = (cnt_r != '0);
  assign out_result.value_byte = head.res[sub_r].value_byte;
  assign out_result.byte_valid = head.res[sub_r].byte_valid;
  assign out_result.end_mark   = head.res[sub_r].end_mark;
  assign out_result.status     = head.res[sub_r].status;

`include "query_param_extract_decode_macros.svh"

  `QPX_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= QPX_CNT_W'(QPX_DEPTH), "result queue over depth")
  `QPX_ASSERT_NOW(a_slot_reserved, s1_valid_r, cnt_r < QPX_CNT_W'(QPX_DEPTH), "decoded word has no queue slot")
  `QPX_ASSERT_NOW(a_head_live, out_result.valid, head.n != '0 && QPX_N_W'(sub_r) < head.n, "result index beyond head group")

endmodule

`default_nettype wire

// ===== tb/qpx_decode_checker.sv =====
module qpx_decode_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  qpx_path_if                           path_mon,
  qpx_result_if                         res_mon,
  input  logic                          cfg_we,
  input  logic [qpx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data,
  output int                            mismatch_count,
  output int                            pending_words
);
  timeunit 1ns;
  timeprecision 1ps;
  import qpx_pkg::*;

  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam int         MAX_LINES = 50;

  typedef enum logic [2:0] {
    PH_SEEK, PH_KEY, PH_SKIP, PH_VALUE, PH_DONE
  } scan_phase_t;

  // register copies
  logic [63:0] key_bytes;
  logic [3:0]  key_len;
  logic [15:0] capacity;

  // scanner state
  scan_phase_t ph;
  logic [3:0]  pos;
  logic [1:0]  esc;
  logic [7:0]  held_hex;
  logic [15:0] written;
  int          step_words;

  result_t predicted_words[$];

  initial begin
    mismatch_count = 0;
    pending_words  = 0;
  end

  function automatic void clear_scan();
    ph       = PH_SEEK;
    pos      = '0;
    esc      = '0;
    held_hex = '0;
    written  = '0;
  endfunction

  function automatic int hex_val(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
    return -1;
  endfunction

  // a single path word yields at most four result words
  function automatic void emit(logic [7:0] b, logic v, logic e, status_t st);
    result_t r;
    if (step_words < QPX_RESULTS) begin
      r.value_byte = b;
      r.byte_valid = v;
      r.end_mark   = e;
      r.status     = st;
      predicted_words.push_back(r);
      step_words++;
    end
  endfunction

  function automatic void close_path(status_t st);
    emit(8'h00, 1'b0, 1'b1, st);
    ph = PH_DONE;
  endfunction

  // returns 0 when the byte did not fit and the path was closed
  function automatic bit put_value(logic [7:0] c);
    if (int'(written) + 1 >= int'(capacity)) begin
      close_path(ST_TOO_LONG);
      return 1'b0;
    end
    emit(c, 1'b1, 1'b0, ST_FOUND);
    written = written + 16'd1;
    return 1'b1;
  endfunction

  // flush a half-seen escape literally, then close as found
  function automatic void finish_value();
    logic [1:0] pend;
    pend = esc;
    esc  = '0;
    if (pend >= 2'd1) begin
      if (!put_value(CH_PCT)) return;
    end
    if (pend == 2'd2) begin
      if (!put_value(held_hex)) return;
    end
    close_path(ST_FOUND);
  endfunction

  function automatic void value_in(logic [7:0] c);
    int lo;
    int hi;
    if (esc == 2'd1) begin
      if (hex_val(c) >= 0) begin
        held_hex = c;
        esc      = 2'd2;
        return;
      end
      esc = '0;
      if (!put_value(CH_PCT)) return;
    end else if (esc == 2'd2) begin
      lo  = hex_val(c);
      esc = '0;
      if (lo >= 0) begin
        hi = hex_val(held_hex);
        if (hi < 0) hi = 0;
        void'(put_value(8'(hi * 16 + lo)));
        return;
      end
      if (!put_value(CH_PCT)) return;
      if (!put_value(held_hex)) return;
    end
    // breaking byte is handled as a fresh one
    if (c == CH_AMP) finish_value();
    else if (c == CH_PCT) esc = 2'd1;
    else void'(put_value(c));
  endfunction

  function automatic void key_in(logic [7:0] c);
    int klen;
    klen = (int'(key_len) > MAX_KEY_BYTES) ? MAX_KEY_BYTES : int'(key_len);
    if (c == CH_AMP) begin
      pos = '0;
      return;
    end
    if (int'(pos) < klen) begin
      if (c == key_bytes[8*pos[2:0] +: 8]) pos = pos + 4'd1;
      else ph = PH_SKIP;
    end else if (c == CH_EQ) begin
      ph      = PH_VALUE;
      written = '0;
      esc     = '0;
    end else begin
      ph = PH_SKIP;
    end
  endfunction

  function automatic void predict_path_byte(logic [7:0] c, logic last);
    step_words = 0;
    case (ph)
      PH_SEEK: begin
        if (c == CH_QUERY) begin
          ph  = PH_KEY;
          pos = '0;
        end
      end
      PH_KEY: key_in(c);
      PH_SKIP: begin
        if (c == CH_AMP) begin
          ph  = PH_KEY;
          pos = '0;
        end
      end
      PH_VALUE: value_in(c);
      default: ;
    endcase
    if (last) begin
      if (ph == PH_VALUE) finish_value();
      else if (ph != PH_DONE) close_path(ST_ABSENT);
      clear_scan();
    end
  endfunction

  task automatic report(string what, int got, int want);
    if (mismatch_count < MAX_LINES)
      $display("%0t mismatch: %s got %0h expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      key_bytes = '0;
      key_len   = '0;
      capacity  = 16'd256;
      clear_scan();
      predicted_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY_CHARS:      key_bytes = cfg_data;
          CFG_KEY_LENGTH:     key_len   = cfg_data[3:0];
          CFG_VALUE_CAPACITY: capacity  = cfg_data[15:0];
          default: ;
        endcase
      end
      if (res_mon.valid && res_mon.ready) begin
        if (predicted_words.size() == 0) begin
          report("unexpected word, value_byte", res_mon.value_byte, 0);
        end else begin
          want = predicted_words.pop_front();
          if (res_mon.value_byte !== want.value_byte)
            report("value_byte", res_mon.value_byte, want.value_byte);
          if (res_mon.byte_valid !== want.byte_valid)
            report("byte_valid", res_mon.byte_valid, want.byte_valid);
          if (res_mon.end_mark !== want.end_mark)
            report("end_mark", res_mon.end_mark, want.end_mark);
          if (res_mon.status !== want.status)
            report("status", res_mon.status, want.status);
        end
      end
      // results trail their path word through the input register and the queue
      if (path_mon.valid && path_mon.ready)
        predict_path_byte(path_mon.path_byte, path_mon.final_byte);
    end
    pending_words = predicted_words.size();
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qpx_pkg::*;

  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PCT   = 8'h25;

  localparam int STALL_LIMIT   = 2000; // quiet cycles before giving up
  localparam int HOLD_CYCLES   = 300;  // long receiver hold-off
  localparam int SETTLE_CYCLES = 12;   // input register + decode + queue slack
  localparam int PHASES        = 8;
  localparam int WORDS_PER_PH  = 57;   // ~460 random path words overall

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0]          cfg_data;

  qpx_path_if   in_path();
  qpx_result_if out_result();

  int mismatch_count;
  int pending_words;
  int words_sent;
  int quiet_cycles;

  bit gaps_on;        // random idling on both sides
  bit hold_request;   // asks the receiver for one long hold-off
  int hold_left;

  logic [7:0] path_buf[$];
  string      hex_digits = "0123456789abcdefABCDEF";
  string      breakers   = "gGxz&=?%/ .";

  query_param_extract_decode dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_path    (in_path),
    .out_result (out_result),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  qpx_decode_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .path_mon       (in_path),
    .res_mon        (out_result),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_words  (pending_words)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: any accepted word on either side rearms it.
  always @(posedge clk) begin
    if ((in_path.valid && in_path.ready) || (out_result.valid && out_result.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("** query_param_extract_decode: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request so the
  // result queue fills and the block has to stall its input.
  initial begin
    out_result.ready = 1'b0;
    hold_left        = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_result.ready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        out_result.ready <= 1'b0;
      end else begin
        out_result.ready <= !(gaps_on && $urandom_range(0, 99) < 13);
      end
    end
  end

  // All tasks below start and end on a falling edge.

  // Three back-to-back register writes; cfg_we drops after the last one.
  task automatic set_config(logic [63:0] key, logic [3:0] len, logic [15:0] cap);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_KEY_CHARS;
    cfg_data  <= key;
    @(negedge clk);
    cfg_index <= CFG_KEY_LENGTH;
    cfg_data  <= 64'(len);
    @(negedge clk);
    cfg_index <= CFG_VALUE_CAPACITY;
    cfg_data  <= 64'(cap);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // valid stays high from one word to the next unless a gap is drawn
  task automatic send_word(logic [7:0] b, logic last);
    while (gaps_on && $urandom_range(0, 99) < 13) begin
      in_path.valid <= 1'b0;
      @(negedge clk);
    end
    in_path.valid      <= 1'b1;
    in_path.path_byte  <= b;
    in_path.final_byte <= last;
    @(posedge clk);
    while (!in_path.ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_path();
    foreach (path_buf[i]) send_word(path_buf[i], i == path_buf.size() - 1);
    path_buf.delete();
  endtask

  // Block is idle once every predicted word is out and the pipe has emptied;
  // words that produce nothing may still be in flight, hence the settle.
  task automatic drain();
    in_path.valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) path_buf.push_back(s[i]);
  endfunction

  function automatic logic [7:0] name_char();
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  function automatic logic [7:0] hex_char();
    return hex_digits[$urandom_range(0, hex_digits.len() - 1)];
  endfunction

  function automatic logic [7:0] breaker_char();
    if ($urandom_range(0, 1) == 0) return 8'($urandom);
    return breakers[$urandom_range(0, breakers.len() - 1)];
  endfunction

  // One piece of a value: plain bytes, good escapes and broken ones.
  function automatic void add_value_token();
    case ($urandom_range(0, 9))
      0, 1, 2: path_buf.push_back(name_char());
      3:       path_buf.push_back(8'($urandom));
      4, 5: begin
        path_buf.push_back(CH_PCT);
        path_buf.push_back(hex_char());
        path_buf.push_back(hex_char());
      end
      6: begin
        path_buf.push_back(CH_PCT);
        path_buf.push_back(hex_char());
        path_buf.push_back(breaker_char());
      end
      7: begin
        path_buf.push_back(CH_PCT);
        path_buf.push_back(breaker_char());
      end
      8:       path_buf.push_back($urandom_range(0, 1) ? CH_EQ : CH_QUERY);
      default: path_buf.push_back(8'($urandom_range(8'h30, 8'h39)));
    endcase
  endfunction

  // Mostly well-formed query strings whose pairs hit the key exactly, with
  // near misses, stray noise paths and trailing garbage mixed in.
  function automatic void make_path(logic [63:0] key, int klen);
    int kind;
    int cut;
    int npairs;
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 6)) path_buf.push_back(8'($urandom));
      return;
    end
    repeat ($urandom_range(0, 3)) path_buf.push_back(name_char());
    path_buf.push_back(CH_QUERY);
    npairs = $urandom_range(1, 3);
    for (int p = 0; p < npairs; p++) begin
      if (p > 0) path_buf.push_back(CH_AMP);
      kind = $urandom_range(0, 99);
      if (kind < 65 || klen == 0) begin
        for (int i = 0; i < klen; i++) path_buf.push_back(key[8*i +: 8]);
      end else if (kind < 80) begin
        cut = $urandom_range(0, klen - 1);
        for (int i = 0; i < klen; i++)
          path_buf.push_back(i == cut ? key[8*i +: 8] ^ 8'($urandom_range(1, 255))
                                      : key[8*i +: 8]);
      end else if (kind < 88) begin
        cut = $urandom_range(0, klen - 1);
        for (int i = 0; i < cut; i++) path_buf.push_back(key[8*i +: 8]);
      end else begin
        repeat ($urandom_range(1, 3)) path_buf.push_back(name_char());
      end
      if ($urandom_range(0, 99) < 90) path_buf.push_back(CH_EQ);
      repeat ($urandom_range(0, 6)) add_value_token();
    end
    if ($urandom_range(0, 99) < 10) path_buf.push_back(8'($urandom));
  endfunction

  // Random key bytes, mostly letters so that pairs can actually match.
  function automatic logic [63:0] make_key();
    logic [63:0] k;
    for (int i = 0; i < MAX_KEY_BYTES; i++)
      k[8*i +: 8] = ($urandom_range(0, 99) < 75) ? name_char() : 8'($urandom);
    return k;
  endfunction

  initial begin
    logic [63:0] key;
    logic [3:0]  klen;
    logic [15:0] cap;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_KEY_CHARS;
    cfg_data           = '0;
    in_path.valid      = 1'b0;
    in_path.path_byte  = '0;
    in_path.final_byte = 1'b0;
    gaps_on            = 1'b1;
    hold_request       = 1'b0;
    words_sent         = 0;
    quiet_cycles       = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed ---
    // key "k": lowercase escape ending the value, escape broken after one
    // digit, then a path with no '?' made of the byte extremes
    set_config(64'h6B, 4'd1, 16'd256);
    add_str("?k=%4a");
    send_path();
    add_str("?k=%Fz");
    send_path();
    path_buf.push_back(8'h00);
    path_buf.push_back(8'hFF);
    send_path();
    drain();

    // empty key with zero capacity: first value byte is already too long,
    // the rest of the path is ignored
    set_config(64'h0, 4'd0, 16'd0);
    add_str("?=a&=");
    send_path();
    drain();

    // key length above eight clamps; all-ones key; lone '%' ends the value
    set_config('1, 4'd15, 16'hFFFF);
    add_str("?");
    repeat (MAX_KEY_BYTES) path_buf.push_back(8'hFF);
    add_str("=%");
    send_path();
    drain();

    // --- random phases ---
    words_sent = 0;
    for (int p = 0; p < PHASES; p++) begin
      key  = make_key();
      klen = (p == 0) ? 4'd0 : (p == 3) ? 4'd15 : (p == 5) ? 4'd8
                             : 4'($urandom_range(1, 8));
      cap  = (p == 1) ? 16'd1 : (p == 2) ? 16'hFFFF : (p == 6) ? 16'd2
                              : 16'($urandom_range(3, 10));
      gaps_on = (p != 4);       // phase 4 runs flat out on both sides
      if (p == 2) hold_request = 1'b1;
      set_config(key, klen, cap);
      while (words_sent < (p + 1) * WORDS_PER_PH) begin
        make_path(key, (klen > MAX_KEY_BYTES) ? MAX_KEY_BYTES : int'(klen));
        send_path();
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("** query_param_extract_decode: PASSED **");
    end else begin
      $display("** query_param_extract_decode: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/qpx_pkg.sv
sv/qpx_path_if.sv
sv/qpx_result_if.sv
sv/qpx_step.sv
sv/query_param_extract_decode.sv
tb/qpx_decode_checker.sv
tb/tb.sv
